### design/fdpe_pkg.sv
// Package for the fractional divider parameter encoder.
// Widths, limits, sequencer constants and the divider handshake types.
// Used by fdpe_divider and fractional_divider_param_encoder.
`default_nettype none
package fdpe_pkg;

  localparam int MAX_DEN_BITS = 20;
  localparam logic [MAX_DEN_BITS-1:0] DEN_LIMIT = '1;

  localparam int A_W   = 12;
  localparam int NUM_W = 32;
  localparam int P_W   = 33;   // convergent numerators stay below 2^33
  localparam int P1_W  = 18;
  localparam int P23_W = 20;

  localparam int DIVD_W    = 40;
  localparam int DIVS_W    = 32;
  localparam int DIV_CNT_W = 6;

  localparam logic [DIV_CNT_W-1:0] CF_DIV_STEPS  = DIV_CNT_W'(NUM_W);
  localparam logic [DIV_CNT_W-1:0] FIN_DIV_STEPS = DIV_CNT_W'(DIVD_W);

  localparam logic [P1_W-1:0] P1_OFFSET = P1_W'(512);
  localparam logic [A_W-1:0]  DIV4_A    = A_W'(4);
  localparam logic            FUNC_MULTISYNTH = 1'b1;

  typedef struct packed {
    logic                 start;
    logic [DIV_CNT_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic step;   // one quotient bit produced this cycle
    logic qbit;   // value of that bit
    logic done;   // quotient and remainder registers are final
  } div_stat_t;

endpackage
`default_nettype wire

### design/fdpe_divider.sv
// Shared restoring shift-subtract divider, one quotient bit per cycle.
// Depends on fdpe_pkg for widths and the request/status structs.
`default_nettype none
module fdpe_divider (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fdpe_pkg::div_req_t            req,
  input  logic [fdpe_pkg::DIVD_W-1:0]   dividend,
  input  logic [fdpe_pkg::DIVS_W-1:0]   divisor,
  output fdpe_pkg::div_stat_t           stat,
  output logic [fdpe_pkg::DIVD_W-1:0]   quotient,
  output logic [fdpe_pkg::DIVS_W-1:0]   remainder
);
  import fdpe_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIVD_W-1:0]    quo_r;
  logic [DIVS_W-1:0]    rem_r;
  logic [DIVS_W-1:0]    dsr_r;

  logic [DIVS_W:0]      trial;
  logic [DIVS_W:0]      diff;
  logic                 ge;
  logic [DIVS_W-1:0]    rem_step;

  always_comb begin
    trial    = {rem_r, quo_r[DIVD_W-1]};
    diff     = trial - {1'b0, dsr_r};
    ge       = (trial >= {1'b0, dsr_r});
    rem_step = ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == DIV_CNT_W'(1));
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // quotient bits shift in at the bottom as dividend bits leave the top
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIVD_W-2:0], ge};
      rem_r <= rem_step;
    end
  end

  assign stat.step = busy_r;
  assign stat.qbit = ge;
  assign stat.done = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

### design/fractional_divider_param_encoder.sv
// Top level: sequencer for continued-fraction limiting and P1/P2/P3 encoding.
// Depends on fdpe_pkg and fdpe_divider.
//
// channel  | ports                                              | handshake
// ---------+----------------------------------------------------+--------------------------
// input    | in_func in_integer_part in_fraction_num/den        | start && !busy
// result   | out_p1/p2/p3_word out_divby4 out_integer_mode      | out_valid, one cycle
//          | out_den_error                                      |
//
// Zero denominator: result in the cycle after the word is taken, busy stays low.
// Denominator within the limit: result after S_FIN and one final divide in S_FIN_DIV,
// or straight from S_FIN for divide-by-4 or a zero numerator.
// Larger denominator: k passes of S_CF_CHK and S_CF_DIV come first, each one 32-bit divide whose
// quotient bits also build a*q and a*p; a last S_CF_CHK pass if the remainder runs out.
// Reset clears the sequencer only; the receiver cannot stall, busy is high while working.
`default_nettype none
module fractional_divider_param_encoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_func,
  input  logic [fdpe_pkg::A_W-1:0]      in_integer_part,
  input  logic [fdpe_pkg::NUM_W-1:0]    in_fraction_num,
  input  logic [fdpe_pkg::NUM_W-1:0]    in_fraction_den,
  output logic                          out_valid,
  output logic [fdpe_pkg::P1_W-1:0]     out_p1_word,
  output logic [fdpe_pkg::P23_W-1:0]    out_p2_word,
  output logic [fdpe_pkg::P23_W-1:0]    out_p3_word,
  output logic                          out_divby4,
  output logic                          out_integer_mode,
  output logic                          out_den_error
);
  import fdpe_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_CF_CHK  = 3'd1;
  localparam logic [2:0] S_CF_DIV  = 3'd2;
  localparam logic [2:0] S_FIN     = 3'd3;
  localparam logic [2:0] S_FIN_DIV = 3'd4;

  logic [2:0]              state_r;
  logic                    func_r;
  logic [A_W-1:0]          a_r;
  logic [NUM_W-1:0]        n_r;
  logic [NUM_W-1:0]        d_r;
  logic [P_W-1:0]          p0_r;
  logic [P_W-1:0]          p1_r;
  logic [MAX_DEN_BITS-1:0] q0_r;
  logic [MAX_DEN_BITS-1:0] q1_r;
  logic [MAX_DEN_BITS-1:0] mq_r;
  logic [P_W-1:0]          mp_r;
  logic                    ovf_r;
  logic [P_W-1:0]          fnum_r;
  logic [MAX_DEN_BITS-1:0] fden_r;

  logic                    accept;
  logic [MAX_DEN_BITS:0]   q2;
  logic                    cf_stop;
  logic                    fin_div4;
  logic                    fin_zero;
  logic [P1_W-1:0]         p1_base;
  logic [MAX_DEN_BITS+1:0] mq_sum;
  logic [P_W-1:0]          mp_sum;

  div_req_t                div_req;
  div_stat_t               div_stat;
  logic [DIVD_W-1:0]       div_dividend;
  logic [DIVS_W-1:0]       div_divisor;
  logic [DIVD_W-1:0]       div_quo;
  logic [DIVS_W-1:0]       div_rem;

  fdpe_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (div_req),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .stat      (div_stat),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    accept   = start && !busy;
    q2       = {1'b0, q0_r} + {1'b0, mq_r};
    cf_stop  = ovf_r || (q2 > {1'b0, DEN_LIMIT});
    fin_div4 = (func_r == FUNC_MULTISYNTH) && (a_r == DIV4_A);
    fin_zero = (fnum_r == '0);
    p1_base  = P1_W'({a_r, 7'b0}) - P1_OFFSET;
    // Horner form of a*q1 and a*p1 as quotient bits arrive, MSB first
    mq_sum   = {1'b0, mq_r, 1'b0} + (MAX_DEN_BITS+2)'(div_stat.qbit ? q1_r : '0);
    mp_sum   = {mp_r[P_W-2:0], 1'b0} + (div_stat.qbit ? p1_r : '0);

    div_req.start = ((state_r == S_CF_CHK) && (d_r != '0)) ||
                    ((state_r == S_FIN) && !fin_div4 && !fin_zero);
    div_req.steps = (state_r == S_CF_CHK) ? CF_DIV_STEPS : FIN_DIV_STEPS;
    div_dividend  = (state_r == S_CF_CHK) ? {n_r, {(DIVD_W-NUM_W){1'b0}}}
                                          : {fnum_r, 7'b0};
    div_divisor   = (state_r == S_CF_CHK) ? d_r : DIVS_W'(fden_r);
  end

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_fraction_den == '0) begin
              out_valid <= 1'b1;
            end else if (in_fraction_den[NUM_W-1:MAX_DEN_BITS] == '0) begin
              state_r <= S_FIN;
            end else begin
              state_r <= S_CF_CHK;
            end
          end
        end
        S_CF_CHK: begin
          state_r <= (d_r == '0) ? S_FIN : S_CF_DIV;
        end
        S_CF_DIV: begin
          if (div_stat.done) begin
            state_r <= cf_stop ? S_FIN : S_CF_CHK;
          end
        end
        S_FIN: begin
          if (fin_div4 || fin_zero) begin
            out_valid <= 1'b1;
            state_r   <= S_IDLE;
          end else begin
            state_r <= S_FIN_DIV;
          end
        end
        S_FIN_DIV: begin
          if (div_stat.done) begin
            out_valid <= 1'b1;
            state_r   <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          func_r <= in_func;
          a_r    <= in_integer_part;
          n_r    <= in_fraction_num;
          d_r    <= in_fraction_den;
          p0_r   <= '0;
          p1_r   <= P_W'(1);
          q0_r   <= MAX_DEN_BITS'(1);
          q1_r   <= '0;
          fnum_r <= P_W'(in_fraction_num);
          fden_r <= in_fraction_den[MAX_DEN_BITS-1:0];
          out_p1_word      <= '0;
          out_p2_word      <= '0;
          out_p3_word      <= '0;
          out_divby4       <= 1'b0;
          out_integer_mode <= 1'b0;
          out_den_error    <= 1'b1;
        end
      end
      S_CF_CHK: begin
        mq_r  <= '0;
        mp_r  <= '0;
        ovf_r <= 1'b0;
        if (d_r == '0) begin
          fnum_r <= p1_r;
          fden_r <= q1_r;
        end
      end
      S_CF_DIV: begin
        if (div_stat.step) begin
          // once a*q1 passes the limit it only grows: keep the flag sticky
          if (mq_sum > (MAX_DEN_BITS+2)'(DEN_LIMIT)) begin
            ovf_r <= 1'b1;
          end
          mq_r <= mq_sum[MAX_DEN_BITS-1:0];
          mp_r <= mp_sum;
        end
        if (div_stat.done) begin
          if (cf_stop) begin
            fnum_r <= p1_r;
            fden_r <= q1_r;
          end else begin
            p0_r <= p1_r;
            q0_r <= q1_r;
            p1_r <= p0_r + mp_r;
            q1_r <= q2[MAX_DEN_BITS-1:0];
            n_r  <= d_r;
            d_r  <= div_rem;
          end
        end
      end
      S_FIN: begin
        out_integer_mode <= fin_zero;
        out_den_error    <= 1'b0;
        if (fin_div4) begin
          out_p1_word <= '0;
          out_p2_word <= '0;
          out_p3_word <= P23_W'(1);
          out_divby4  <= 1'b1;
        end else if (fin_zero) begin
          out_p1_word <= p1_base;
          out_p2_word <= '0;
          out_p3_word <= P23_W'(1);
          out_divby4  <= 1'b0;
        end
      end
      S_FIN_DIV: begin
        if (div_stat.done) begin
          out_p1_word      <= p1_base + div_quo[P1_W-1:0];
          out_p2_word      <= P23_W'(div_rem);
          out_p3_word      <= P23_W'(fden_r);
          out_divby4       <= 1'b0;
          out_integer_mode <= 1'b0;
          out_den_error    <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_fin_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) |-> (fden_r != '0))
    else $error("final denominator is zero");

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == S_IDLE))
    else $error("result strobe while sequencer busy");

  a_zero_den_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_fraction_den == '0)) |=>
      (out_valid && out_den_error && (out_p1_word == '0) && (out_p3_word == '0)))
    else $error("zero denominator not flagged in the next cycle");

  a_divby4_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_divby4) |->
      ((out_p1_word == '0) && (out_p2_word == '0) && (out_p3_word == P23_W'(1)) &&
       !out_den_error))
    else $error("divide-by-4 result with wrong parameters");
`endif

endmodule
`default_nettype wire

### tb/fractional_divider_param_encoder_tb.sv
// Testbench for fractional_divider_param_encoder: directed and random divider words,
// each checked field by field against a built-in parameter encoder.
// Depends on fdpe_pkg and the design top level only.
`timescale 1ns / 100ps
`default_nettype none
module fractional_divider_param_encoder_tb;
  import fdpe_pkg::*;

  localparam logic [63:0] DEN_CAP     = (64'd1 << MAX_DEN_BITS) - 64'd1;
  localparam int          CYCLE_LIMIT = 3_000_000;
  localparam int          RANDOM_WORDS = 480;
  localparam int          CALM_TAIL    = 60;

  typedef struct packed {
    logic [P1_W-1:0]  p1;
    logic [P23_W-1:0] p2;
    logic [P23_W-1:0] p3;
    logic             divby4;
    logic             imode;
    logic             den_err;
  } divider_params_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                in_func = 1'b0;
  logic [A_W-1:0]      in_integer_part = '0;
  logic [NUM_W-1:0]    in_fraction_num = '0;
  logic [NUM_W-1:0]    in_fraction_den = '0;
  logic                out_valid;
  logic [P1_W-1:0]     out_p1_word;
  logic [P23_W-1:0]    out_p2_word;
  logic [P23_W-1:0]    out_p3_word;
  logic                out_divby4;
  logic                out_integer_mode;
  logic                out_den_error;

  divider_params_t pending_params[$];
  int              fail_count = 0;
  int              cycle_count = 0;
  bit              idle_enable = 1'b1;

  fractional_divider_param_encoder u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_integer_part  (in_integer_part),
    .in_fraction_num  (in_fraction_num),
    .in_fraction_den  (in_fraction_den),
    .out_valid        (out_valid),
    .out_p1_word      (out_p1_word),
    .out_p2_word      (out_p2_word),
    .out_p3_word      (out_p3_word),
    .out_divby4       (out_divby4),
    .out_integer_mode (out_integer_mode),
    .out_den_error    (out_den_error)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Expected P1/P2/P3 and flags for one divider word.
  function automatic divider_params_t encode_divider(logic func, logic [A_W-1:0] a,
                                                     logic [NUM_W-1:0] num_in,
                                                     logic [NUM_W-1:0] den_in);
    divider_params_t res;
    logic [63:0] n, d, rem_n, rem_d, tmp, quo, q_next;
    logic [63:0] p_prev, p_cur, q_prev, q_cur, p1_full, n128;
    bit          stop;
    res = '0;
    res.p3 = P23_W'(1);
    if (den_in == '0) begin
      res = '0;
      res.den_err = 1'b1;
      return res;
    end
    n = 64'(num_in);
    d = 64'(den_in);
    // Walk the convergents until the remainder runs out or the next denominator would pass the cap.
    if (d > DEN_CAP) begin
      rem_n = n; rem_d = d;
      p_prev = 0; q_prev = 1; p_cur = 1; q_cur = 0;
      stop = 1'b0;
      while (rem_d != 0 && !stop) begin
        quo = rem_n / rem_d;
        q_next = q_prev + quo * q_cur;
        if (q_next > DEN_CAP) begin
          stop = 1'b1;
        end else begin
          tmp = p_prev + quo * p_cur;
          p_prev = p_cur; p_cur = tmp;
          q_prev = q_cur; q_cur = q_next;
          tmp = rem_n % rem_d;
          rem_n = rem_d; rem_d = tmp;
        end
      end
      n = p_cur;
      d = q_cur;
    end
    res.imode = (n == 0);
    if (func == FUNC_MULTISYNTH && a == DIV4_A) begin
      res.divby4 = 1'b1;
    end else begin
      p1_full = (64'(a) << 7) - 64'(P1_OFFSET);
      if (n != 0) begin
        n128 = n << 7;
        p1_full = p1_full + n128 / d;
        res.p2 = P23_W'(n128 % d);
        res.p3 = P23_W'(d);
      end
      res.p1 = P1_W'(p1_full);
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h", cycle_count, what, got,
             want);
    fail_count++;
  endtask

  // Hold start high until the word is taken, then queue its expected result.
  task automatic send_word(logic func, logic [A_W-1:0] a, logic [NUM_W-1:0] num,
                           logic [NUM_W-1:0] den);
    start <= 1'b1;
    in_func <= func;
    in_integer_part <= a;
    in_fraction_num <= num;
    in_fraction_den <= den;
    do @(posedge clk); while (busy);
    pending_params.push_back(encode_divider(func, a, num, den));
  endtask

  task automatic maybe_idle();
    if (idle_enable && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic test_zero_den();
    send_word(1'b0, 12'd0, 32'd0, 32'd0);
    send_word(1'b1, DIV4_A, 32'd123, 32'd0);
    maybe_idle();
    send_word(1'b1, 12'hFFF, 32'hFFFF_FFFF, 32'd0);
  endtask

  task automatic test_integer_mode();
    send_word(1'b0, 12'd36, 32'd0, 32'd1000);
    send_word(1'b1, 12'd100, 32'd0, 32'hFFFF_FFFF);
    // Tiny fraction over a huge denominator collapses to zero.
    send_word(1'b0, 12'd90, 32'd1, 32'hFFFF_FFFF);
  endtask

  task automatic test_divby4();
    send_word(1'b1, DIV4_A, 32'd0, 32'd1);
    maybe_idle();
    send_word(1'b1, DIV4_A, 32'd5, 32'd7);
    send_word(1'b1, DIV4_A, 32'd1, 32'hFFFF_FFFF);
    send_word(1'b1, DIV4_A, 32'h1234_5678, 32'h9ABC_DEF0);
    send_word(1'b0, DIV4_A, 32'd3, 32'd10);
  endtask

  task automatic test_num_over_den();
    send_word(1'b0, 12'd50, 32'hFFFF_FFFF, 32'd1);
    send_word(1'b1, 12'hFFF, 32'hFFFF_FFFF, 32'd3);
    maybe_idle();
    send_word(1'b0, 12'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_word(1'b1, 12'd7, 32'd1000, 32'd999);
  endtask

  task automatic test_den_cap();
    send_word(1'b0, 12'd40, 32'd12345, 32'h000F_FFFF);
    send_word(1'b1, 12'd8, 32'h0007_FFFF, 32'h0010_0000);
    maybe_idle();
    send_word(1'b0, 12'd2048, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    // Golden-ratio fraction takes the most convergent steps.
    send_word(1'b1, 12'd6, 32'h9E37_79B9, 32'hFFFF_FFFF);
    send_word(1'b0, 12'hAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    send_word(1'b1, 12'h555, 32'h0000_FFFF, 32'h8000_0001);
  endtask

  task automatic test_random();
    logic             func;
    logic [A_W-1:0]   a;
    logic [NUM_W-1:0] num, den;
    int               sel;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      idle_enable = (i < RANDOM_WORDS - CALM_TAIL) && ((i / 40) % 3 != 2);
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        den = '0;
      end else if (sel < 35) begin
        den = NUM_W'(DEN_CAP) >> $urandom_range(0, MAX_DEN_BITS - 1);
        den = den & $urandom;
      end else if (sel < 45) begin
        den = $urandom_range(32'h000F_FFFC, 32'h0010_0003);
      end else begin
        den = $urandom >> $urandom_range(0, 11);
      end
      sel = $urandom_range(0, 99);
      if (sel < 10) num = '0;
      else if (sel < 25 || den == '0) num = $urandom;
      else num = $urandom % den;
      func = 1'($urandom_range(0, 1));
      a = ($urandom_range(0, 99) < 8) ? DIV4_A : A_W'($urandom_range(0, 4095));
      send_word(func, a, num, den);
      maybe_idle();
    end
  endtask

  // Compare each result word with the oldest expectation.
  always @(posedge clk) begin
    divider_params_t want;
    if (rst_n && out_valid) begin
      if (pending_params.size() == 0) begin
        report_mismatch("unexpected result word, p1", out_p1_word, 0);
      end else begin
        want = pending_params.pop_front();
        if (out_p1_word !== want.p1) report_mismatch("p1_word", out_p1_word, want.p1);
        if (out_p2_word !== want.p2) report_mismatch("p2_word", out_p2_word, want.p2);
        if (out_p3_word !== want.p3) report_mismatch("p3_word", out_p3_word, want.p3);
        if (out_divby4 !== want.divby4)
          report_mismatch("divby4", out_divby4, want.divby4);
        if (out_integer_mode !== want.imode)
          report_mismatch("integer_mode", out_integer_mode, want.imode);
        if (out_den_error !== want.den_err)
          report_mismatch("den_error", out_den_error, want.den_err);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_zero_den();
    test_integer_mode();
    test_divby4();
    test_num_over_den();
    test_den_cap();
    test_random();
    start <= 1'b0;
    while (pending_params.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
